// File: design/slr_pkg.sv
// Shared types and constants of the spectrum linear resampler.
package slr_pkg;

	// Width of positions, values and results.
	localparam int DATA_W = 32;
	// Width of the shared add/subtract unit: one sign bit and one carry bit above the data.
	localparam int ALU_W = DATA_W + 2;
	// Width of the division step counter.
	localparam int DIV_CNT_W = $clog2(DATA_W);
	localparam int STATUS_W = 3;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_OUTSIDE  = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOT_INCR = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

// File: design/slr_addsub.sv
// Shared signed add/subtract unit used by the add, subtract, compare and division steps of the resampler.
module slr_addsub (
	input  slr_pkg::alu_op_t                op,
	input  logic signed [slr_pkg::ALU_W-1:0] a,
	input  logic signed [slr_pkg::ALU_W-1:0] b,
	output logic signed [slr_pkg::ALU_W-1:0] y
);
	import slr_pkg::*;

	always_comb begin
		case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
	end

endmodule

// File: design/slr_table.sv
// Position and value memories of the source point table, one write and one registered read port.
module slr_table #(
	parameter int DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(DEPTH)-1:0]          wr_addr,
	input  logic signed [slr_pkg::DATA_W-1:0] wr_pos,
	input  logic signed [slr_pkg::DATA_W-1:0] wr_val,
	input  logic [$clog2(DEPTH)-1:0]          rd_addr,
	output logic signed [slr_pkg::DATA_W-1:0] rd_pos,
	output logic signed [slr_pkg::DATA_W-1:0] rd_val
);
	import slr_pkg::*;

	logic signed [DATA_W-1:0] pos_mem [DEPTH];
	logic signed [DATA_W-1:0] val_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[wr_addr] <= wr_pos;
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		rd_pos <= pos_mem[rd_addr];
		rd_val <= val_mem[rd_addr];
	end

endmodule

// File: design/spectrum_linear_resampler.sv
// Top level of the spectrum linear resampler: request decode, sequencer and result register.
//
// Usage: a request is accepted at a rising edge where start is high and busy is low.
// req_type selects clear (empties the table), load (appends point_position/point_value)
// or query (interpolates at query_position). Every request gives exactly one result:
// result_value and status are valid for the single cycle in which done is high, and
// the receiver must take them then; there is no way to hold a result off.
// Clear, load, unused codes and queries that hit the empty table, fall outside the
// table or land on the last position finish without the sequencer: done rises in the cycle
// after the accept and busy never rises, so a request may be issued every cycle.
// Any other query runs a binary search over the position memory (one read and one
// compare per step), reads the enclosing pair, and then uses the single shared
// add/subtract unit for the differences, the 32 steps of a restoring division and
// the final add or subtract. busy stays high while the query runs; the search takes
// at most ceil(log2(point_count + 1)) steps. done is high in the first cycle after the
// last busy cycle, and a new request may be accepted in that same cycle. Reset
// empties the table and clears done and busy; the memories themselves are not
// cleared, as only entries below the point count are read.
module spectrum_linear_resampler #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         req_type,
	input  logic signed [slr_pkg::DATA_W-1:0]  point_position,
	input  logic signed [slr_pkg::DATA_W-1:0]  point_value,
	input  logic signed [slr_pkg::DATA_W-1:0]  query_position,
	output logic                               done,
	output logic signed [slr_pkg::DATA_W-1:0]  result_value,
	output logic [slr_pkg::STATUS_W-1:0]       status
);
	import slr_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int EXT_W = ALU_W - DATA_W;

	// Sequencer states, one-hot.
	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_SRCH_RD  = 12'b0000_0000_0010,
		S_SRCH_CMP = 12'b0000_0000_0100,
		S_PAIR_RD0 = 12'b0000_0000_1000,
		S_PAIR_RD1 = 12'b0000_0001_0000,
		S_PAIR_CAP = 12'b0000_0010_0000,
		S_DIFF_DX  = 12'b0000_0100_0000,
		S_DV_SIGN  = 12'b0000_1000_0000,
		S_DV_ABS   = 12'b0001_0000_0000,
		S_MUL      = 12'b0010_0000_0000,
		S_DIV      = 12'b0100_0000_0000,
		S_FINAL    = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// Table bookkeeping.
	logic [CNT_W-1:0]         point_count_q;
	logic signed [DATA_W-1:0] first_pos_q;
	logic signed [DATA_W-1:0] last_pos_q;
	logic signed [DATA_W-1:0] last_val_q;

	// Query working registers.
	logic signed [DATA_W-1:0] x_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [CNT_W-1:0]         mid_q;
	logic signed [DATA_W-1:0] x0_q;
	logic signed [DATA_W-1:0] v0_q;
	logic [DATA_W-1:0]        off_q;
	logic [DATA_W-1:0]        dx_q;
	logic                     dv_neg_q;
	logic [DATA_W-1:0]        absdv_q;
	logic [DATA_W-1:0]        rem_q;
	logic [DATA_W-1:0]        low_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;

	// Result register.
	logic                     done_q;
	logic signed [DATA_W-1:0] result_q;
	logic [STATUS_W-1:0]      status_q;

	// Memory ports.
	logic                     wr_en;
	logic [IDX_W-1:0]         rd_addr;
	logic signed [DATA_W-1:0] rd_pos;
	logic signed [DATA_W-1:0] rd_val;

	// Shared unit ports.
	alu_op_t                 alu_op;
	logic signed [ALU_W-1:0] alu_a;
	logic signed [ALU_W-1:0] alu_b;
	logic signed [ALU_W-1:0] alu_y;
	logic                    alu_nonneg;

	logic                     accept;
	logic                     table_full;
	logic                     table_empty;
	logic                     load_ok;
	logic [CNT_W:0]           mid_sum;
	logic [CNT_W-1:0]         mid;
	logic [CNT_W-1:0]         lo_m1;
	logic [2*DATA_W-1:0]      product;
	logic [DATA_W:0]          div_trial;

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign table_full  = (point_count_q == CNT_W'(TABLE_DEPTH));
	assign table_empty = (point_count_q == '0);
	assign alu_nonneg  = !alu_y[ALU_W-1];

	// In idle the shared unit computes last_pos - point_position; a non-negative
	// difference means the new point does not increase.
	assign load_ok = !table_full && (table_empty || !alu_nonneg);
	assign wr_en   = accept && (req_type == REQ_LOAD) && load_ok;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CNT_W:1];
	assign lo_m1     = lo_q - 1'b1;
	assign product   = off_q * absdv_q;
	assign div_trial = {rem_q, low_q[DATA_W-1]};

	// Read address: the probe during the search, then the lower point of the
	// enclosing pair, then the upper point, which stays addressed until the end.
	always_comb begin
		case (state_q)
			S_SRCH_RD:  rd_addr = mid[IDX_W-1:0];
			S_PAIR_RD0: rd_addr = lo_m1[IDX_W-1:0];
			default:    rd_addr = lo_q[IDX_W-1:0];
		endcase
	end

	// Operand selection for the shared add/subtract unit.
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = {{EXT_W{last_pos_q[DATA_W-1]}}, last_pos_q};
		alu_b  = {{EXT_W{point_position[DATA_W-1]}}, point_position};
		case (state_q)
			S_IDLE: begin
				alu_op = ALU_SUB;
			end
			S_SRCH_CMP: begin
				alu_a = {{EXT_W{x_q[DATA_W-1]}}, x_q};
				alu_b = {{EXT_W{rd_pos[DATA_W-1]}}, rd_pos};
			end
			S_PAIR_CAP: begin
				alu_a = {{EXT_W{x_q[DATA_W-1]}}, x_q};
				alu_b = {{EXT_W{x0_q[DATA_W-1]}}, x0_q};
			end
			S_DIFF_DX: begin
				alu_a = {{EXT_W{rd_pos[DATA_W-1]}}, rd_pos};
				alu_b = {{EXT_W{x0_q[DATA_W-1]}}, x0_q};
			end
			S_DV_SIGN: begin
				alu_a = {{EXT_W{rd_val[DATA_W-1]}}, rd_val};
				alu_b = {{EXT_W{v0_q[DATA_W-1]}}, v0_q};
			end
			S_DV_ABS: begin
				if (dv_neg_q) begin
					alu_a = {{EXT_W{v0_q[DATA_W-1]}}, v0_q};
					alu_b = {{EXT_W{rd_val[DATA_W-1]}}, rd_val};
				end else begin
					alu_a = {{EXT_W{rd_val[DATA_W-1]}}, rd_val};
					alu_b = {{EXT_W{v0_q[DATA_W-1]}}, v0_q};
				end
			end
			S_DIV: begin
				alu_a = {{(ALU_W-DATA_W-1){1'b0}}, div_trial};
				alu_b = {{EXT_W{1'b0}}, dx_q};
			end
			S_FINAL: begin
				alu_op = dv_neg_q ? ALU_SUB : ALU_ADD;
				alu_a  = {{EXT_W{v0_q[DATA_W-1]}}, v0_q};
				alu_b  = {{EXT_W{1'b0}}, low_q};
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	slr_addsub u_addsub (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	slr_table #(
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (point_count_q[IDX_W-1:0]),
		.wr_pos  (point_position),
		.wr_val  (point_value),
		.rd_addr (rd_addr),
		.rd_pos  (rd_pos),
		.rd_val  (rd_val)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			point_count_q <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_CLEAR: begin
								point_count_q <= '0;
								done_q        <= 1'b1;
							end
							REQ_LOAD: begin
								if (load_ok) begin
									point_count_q <= point_count_q + 1'b1;
								end
								done_q <= 1'b1;
							end
							REQ_QUERY: begin
								if (table_empty || (query_position < first_pos_q) ||
								    (query_position >= last_pos_q)) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_SRCH_RD;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SRCH_RD: begin
					state_q <= (lo_q < hi_q) ? S_SRCH_CMP : S_PAIR_RD0;
				end
				S_SRCH_CMP: state_q <= S_SRCH_RD;
				S_PAIR_RD0: state_q <= S_PAIR_RD1;
				S_PAIR_RD1: state_q <= S_PAIR_CAP;
				S_PAIR_CAP: state_q <= S_DIFF_DX;
				S_DIFF_DX:  state_q <= S_DV_SIGN;
				S_DV_SIGN:  state_q <= S_DV_ABS;
				S_DV_ABS:   state_q <= S_MUL;
				S_MUL:      state_q <= S_DIV;
				S_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					result_q <= '0;
					status_q <= ST_OK;
					x_q      <= query_position;
					lo_q     <= '0;
					hi_q     <= point_count_q;
					case (req_type)
						REQ_LOAD: begin
							if (table_full) begin
								status_q <= ST_FULL;
							end else if (!load_ok) begin
								status_q <= ST_NOT_INCR;
							end else begin
								last_pos_q <= point_position;
								last_val_q <= point_value;
								if (table_empty) begin
									first_pos_q <= point_position;
								end
							end
						end
						REQ_QUERY: begin
							if (table_empty) begin
								status_q <= ST_EMPTY;
							end else if ((query_position < first_pos_q) ||
							             (query_position > last_pos_q)) begin
								status_q <= ST_OUTSIDE;
							end else if (query_position == last_pos_q) begin
								result_q <= last_val_q;
							end
						end
						default: begin
							status_q <= ST_OK;
						end
					endcase
				end
			end
			S_SRCH_RD: begin
				mid_q <= mid;
			end
			S_SRCH_CMP: begin
				// The probed position is at or below the query: move past it.
				if (alu_nonneg) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_PAIR_RD1: begin
				x0_q <= rd_pos;
				v0_q <= rd_val;
			end
			S_PAIR_CAP: begin
				// Offset is measured from the lower point captured in the previous cycle.
				off_q <= alu_y[DATA_W-1:0];
			end
			S_DIFF_DX: begin
				dx_q <= alu_y[DATA_W-1:0];
			end
			S_DV_SIGN: begin
				dv_neg_q <= alu_y[ALU_W-1];
			end
			S_DV_ABS: begin
				absdv_q <= alu_y[DATA_W-1:0];
			end
			S_MUL: begin
				// The offset is below dx, so the upper half is already below dx
				// and the quotient fits in one word.
				rem_q     <= product[2*DATA_W-1:DATA_W];
				low_q     <= product[DATA_W-1:0];
				div_cnt_q <= '0;
			end
			S_DIV: begin
				// Restoring division: quotient bits shift in as dividend bits shift out.
				if (alu_nonneg) begin
					rem_q <= alu_y[DATA_W-1:0];
				end else begin
					rem_q <= div_trial[DATA_W-1:0];
				end
				low_q     <= {low_q[DATA_W-2:0], alu_nonneg};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			S_FINAL: begin
				result_q <= alu_y[DATA_W-1:0];
				status_q <= ST_OK;
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;

	// A result is never presented while a query is still being worked on.
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> !done)
		else $error("result strobe while busy");

	// Every accepted request either answers in the next cycle or starts the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> (done || busy))
		else $error("accepted request dropped");

	// The table never holds more points than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_count_q <= CNT_W'(TABLE_DEPTH))
		else $error("point count beyond table depth");

	// The partial remainder stays below the divisor throughout the division.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_DIV) |-> (rem_q < dx_q))
		else $error("division remainder out of range");

endmodule
